@@ hw/rtl/hbba_pkg.sv @@
// ----------------------------------------------------------------------------
// hbba_pkg
// Shared constants and bit functions of the hierarchical bitmap allocator.
// ----------------------------------------------------------------------------
package hbba_pkg;

    localparam int BR_LOG2         = 5;
    localparam int NUM_CLASSES     = 6;
    localparam int TREE_ROWS_DEF   = 2;
    localparam int TREE_ROWS_MAX   = 3;
    localparam int ADDR_W          = 15;
    localparam int LEN_W           = 6;
    localparam int CFG_W           = 6;
    localparam int CLS_W           = 3;
    localparam int OFF_W           = 5;

    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
    localparam logic [31:0] FOLD0    = 32'h5555_5555;
    localparam logic [31:0] FOLD1    = 32'h1111_1111;
    localparam logic [31:0] FOLD2    = 32'h0101_0101;
    localparam logic [31:0] FOLD3    = 32'h0001_0001;
    localparam logic [31:0] PAIR_HI  = 32'haaaa_aaaa;
    localparam logic [31:0] QUAD_HI  = 32'heeee_eeee;
    localparam logic [31:0] OCT_HI   = 32'hfefe_fefe;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    function automatic logic [OFF_W-1:0] first_zero(input logic [31:0] x);
        logic [OFF_W-1:0] idx;
        logic             found;
        idx   = '0;
        found = 1'b0;
        for (int i = 0; i < 32; i++) begin
            if (!found && !x[i]) begin
                idx   = OFF_W'(i);
                found = 1'b1;
            end
        end
        return idx;
    endfunction

    function automatic logic [CLS_W-1:0] size_class(input logic [LEN_W-1:0] n);
        return CLS_W'(32'(n > 6'd1) + 32'(n > 6'd2) + 32'(n > 6'd4) +
                      32'(n > 6'd8) + 32'(n > 6'd16));
    endfunction

    function automatic int row_start(input int r);
        int s;
        s = 0;
        for (int k = 0; k < TREE_ROWS_MAX; k++) begin
            if (k < r) begin
                s = s + (1 << (BR_LOG2 * k));
            end
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/hbba_leaf_update.sv @@
// ----------------------------------------------------------------------------
// hbba_leaf_update
// Run placement, set/clear of a run in one leaf and free size-class count.
// ----------------------------------------------------------------------------
module hbba_leaf_update (
    input  logic [31:0]                leaf_word,
    input  logic [hbba_pkg::CLS_W-1:0] cls,
    input  logic                       op,
    input  logic [hbba_pkg::OFF_W-1:0] free_off,
    output logic [31:0]                new_word,
    output logic [hbba_pkg::OFF_W-1:0] offset,
    output logic [hbba_pkg::CLS_W-1:0] space_end
);
    import hbba_pkg::*;

    logic [31:0]      x1, x2, x3, f, wm, mask, ff;
    logic [OFF_W-1:0] alloc_off, sel_off;
    int               n;

    always_comb begin
        x1 = (leaf_word >> 1) | leaf_word | PAIR_HI;
        x2 = (x1 >> 2) | x1 | QUAD_HI;
        x3 = (cls == CLS_W'(3)) ? ((x2 >> 4) | x2 | OCT_HI) : x2;
        f  = ~x3;
        f  = f & (32'd0 - f);
        case (cls)
            CLS_W'(5): alloc_off = '0;
            CLS_W'(4): alloc_off = (leaf_word[15:0] != 16'd0) ? OFF_W'(16) : OFF_W'(0);
            CLS_W'(3), CLS_W'(2): begin
                alloc_off = {|(f & 32'hffff_0000), |(f & 32'hff00_ff00),
                             (cls == CLS_W'(2)) && (|(f & 32'hf0f0_f0f0)), 2'b00};
            end
            CLS_W'(1): alloc_off = first_zero(x1);
            default:   alloc_off = first_zero(leaf_word);
        endcase
    end

    always_comb begin
        case (cls)
            CLS_W'(0): wm = 32'h0000_0001;
            CLS_W'(1): wm = 32'h0000_0003;
            CLS_W'(2): wm = 32'h0000_000f;
            CLS_W'(3): wm = 32'h0000_00ff;
            CLS_W'(4): wm = 32'h0000_ffff;
            default:   wm = ALL_ONES;
        endcase
        sel_off  = (op == OP_ALLOC) ? alloc_off : free_off;
        mask     = wm << sel_off;
        new_word = (op == OP_ALLOC) ? (leaf_word | mask) : (leaf_word & ~mask);
        offset   = alloc_off;
    end

    always_comb begin
        ff = ~new_word;
        n  = 32'(ff != 32'd0) + 32'(new_word == 32'd0);
        ff = (ff >> 1) & ff & FOLD0;
        n  = n + 32'(ff != 32'd0);
        ff = (ff >> 2) & ff & FOLD1;
        n  = n + 32'(ff != 32'd0);
        ff = (ff >> 4) & ff & FOLD2;
        n  = n + 32'(ff != 32'd0);
        ff = (ff >> 8) & ff & FOLD3;
        n  = n + 32'(ff != 32'd0);
        space_end = CLS_W'(n);
    end

endmodule

@@ hw/rtl/hierarchical_bitmap_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// hierarchical_bitmap_block_allocator_unit
// Power-of-two run allocator over a leaf bitmap with six summary trees.
//
//   channel   direction  ports                                    transfer
//   s_        in         s_op, s_run_length, s_free_address        valid&ready
//   m_        out        m_granted, m_block_address                valid&ready
//   cfg_      in         cfg_wdata (top_branches_in_use)           valid&ready
//
// One request at a time: a read and a use state per tree row of descent, the
// same pair for the leaf read-modify-write and for each summary node updated,
// then a state that loads the result. The next request is taken once the
// unit is back in idle.
// After reset and after each configuration write a clearing pass over all
// 32**TREE_ROWS leaf addresses sweeps both memories.
// A finished result waits in the output register; a later one holds in the
// done state until the register is free. A configuration write wins over a
// waiting request.
// ----------------------------------------------------------------------------
module hierarchical_bitmap_block_allocator_unit #(
    parameter int TREE_ROWS = hbba_pkg::TREE_ROWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [hbba_pkg::LEN_W-1:0]  s_run_length,
    input  logic [hbba_pkg::ADDR_W-1:0] s_free_address,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_granted,
    output logic [hbba_pkg::ADDR_W-1:0] m_block_address,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hbba_pkg::CFG_W-1:0]  cfg_wdata
);
    import hbba_pkg::*;

    localparam int LEAF_W     = BR_LOG2 * TREE_ROWS;
    localparam int LEAF_COUNT = 1 << LEAF_W;
    localparam int STRIDE     = (LEAF_COUNT - 1) / 31;
    localparam int TREE_DEPTH = NUM_CLASSES * STRIDE;
    localparam int TA_W       = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
    localparam int ROW_W      = (TREE_ROWS > 1) ? $clog2(TREE_ROWS) : 1;
    localparam int CMP_W      = ADDR_W + CFG_W + LEAF_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLEAR    = 4'd1;
    localparam logic [3:0] ST_DESC_RD  = 4'd2;
    localparam logic [3:0] ST_DESC_USE = 4'd3;
    localparam logic [3:0] ST_LEAF_RD  = 4'd4;
    localparam logic [3:0] ST_LEAF_USE = 4'd5;
    localparam logic [3:0] ST_UPD_RD   = 4'd6;
    localparam logic [3:0] ST_UPD_USE  = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    logic [31:0] leaf_mem [LEAF_COUNT];
    logic [31:0] tree_mem [TREE_DEPTH];
    logic [31:0] leaf_rdata_reg, tree_rdata_reg;

    logic [3:0]        state_reg, state_next;
    logic [LEAF_W-1:0] clr_reg, clr_next;
    logic [CFG_W-1:0]  top_reg, top_next;
    logic [LEAF_W-1:0] acc_reg, acc_next;
    logic [LEAF_W-1:0] node_reg, node_next;
    logic [OFF_W-1:0]  branch_reg, branch_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CLS_W-1:0]  cc_reg, cc_next;
    logic [CLS_W-1:0]  end_reg, end_next;
    logic              op_reg, op_next;
    logic [CLS_W-1:0]  cls_reg, cls_next;
    logic [OFF_W-1:0]  foff_reg, foff_next;
    logic              res_granted_reg, res_granted_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_granted_reg, m_granted_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;

    logic              leaf_we, tree_we;
    logic [LEAF_W-1:0] leaf_waddr;
    logic [31:0]       leaf_wdata, tree_wdata, absent, bit_mask, upd_word;
    logic [TA_W-1:0]   tree_raddr, tree_waddr;
    logic [31:0]       clr_tree_word;
    logic              clr_is_top;
    logic [31:0]       new_word;
    logic [OFF_W-1:0]  leaf_off;
    logic [CLS_W-1:0]  leaf_end;
    logic [OFF_W-1:0]  fz;
    logic [CFG_W-1:0]  cfg_sat;
    logic              cont;

    hbba_leaf_update u_leaf (
        .leaf_word (leaf_rdata_reg),
        .cls       (cls_reg),
        .op        (op_reg),
        .free_off  (foff_reg),
        .new_word  (new_word),
        .offset    (leaf_off),
        .space_end (leaf_end)
    );

    always_ff @(posedge aclk) begin
        if (leaf_we) begin
            leaf_mem[leaf_waddr] <= leaf_wdata;
        end
        leaf_rdata_reg <= leaf_mem[acc_reg];
    end

    always_ff @(posedge aclk) begin
        if (tree_we) begin
            tree_mem[tree_waddr] <= tree_wdata;
        end
        tree_rdata_reg <= tree_mem[tree_raddr];
    end

    always_comb begin
        absent     = (top_reg >= CFG_W'(32)) ? 32'd0 : ~((32'd1 << top_reg) - 32'd1);
        clr_is_top = 1'b0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (32'(clr_reg) == c * STRIDE) begin
                clr_is_top = 1'b1;
            end
        end
        clr_tree_word = clr_is_top ? absent : 32'd0;

        if (state_reg == ST_UPD_RD || state_reg == ST_UPD_USE) begin
            tree_raddr = TA_W'(32'(cc_reg) * STRIDE + row_start(int'(row_reg)) +
                               32'(node_reg));
        end else begin
            tree_raddr = TA_W'(32'(cls_reg) * STRIDE + row_start(int'(row_reg)) +
                               ((row_reg == '0) ? 32'd0 : 32'(acc_reg)));
        end

        bit_mask = 32'd1 << branch_reg;
        upd_word = (op_reg == OP_ALLOC) ? (tree_rdata_reg | bit_mask)
                                        : (tree_rdata_reg & ~bit_mask);
        cont = (row_reg != '0) &&
               ((op_reg == OP_ALLOC) ? (upd_word == ALL_ONES)
                                     : (tree_rdata_reg == ALL_ONES));

        leaf_we    = (state_reg == ST_CLEAR) || (state_reg == ST_LEAF_USE);
        leaf_waddr = (state_reg == ST_CLEAR) ? clr_reg : acc_reg;
        leaf_wdata = (state_reg == ST_CLEAR) ? 32'd0 : new_word;
        tree_we    = ((state_reg == ST_CLEAR) && (32'(clr_reg) < TREE_DEPTH)) ||
                     (state_reg == ST_UPD_USE);
        tree_waddr = (state_reg == ST_CLEAR) ? TA_W'(clr_reg) : tree_raddr;
        tree_wdata = (state_reg == ST_CLEAR) ? clr_tree_word : upd_word;

        fz = first_zero(tree_rdata_reg);

        if (cfg_wdata < CFG_W'(2)) begin
            cfg_sat = CFG_W'(2);
        end else if (cfg_wdata > CFG_W'(32)) begin
            cfg_sat = CFG_W'(32);
        end else begin
            cfg_sat = cfg_wdata;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready       = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);
    assign m_valid         = m_valid_reg;
    assign m_granted       = m_granted_reg;
    assign m_block_address = m_addr_reg;

    always_comb begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        top_next         = top_reg;
        acc_next         = acc_reg;
        node_next        = node_reg;
        branch_next      = branch_reg;
        row_next         = row_reg;
        cc_next          = cc_reg;
        end_next         = end_reg;
        op_next          = op_reg;
        cls_next         = cls_reg;
        foff_next        = foff_reg;
        res_granted_next = res_granted_reg;
        res_addr_next    = res_addr_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_granted_next   = m_granted_reg;
        m_addr_next      = m_addr_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next   = s_op;
                    cls_next  = size_class(s_run_length);
                    foff_next = s_free_address[OFF_W-1:0];
                    row_next  = '0;
                    if (s_op == OP_ALLOC) begin
                        state_next = ST_DESC_RD;
                    end else begin
                        res_addr_next = s_free_address;
                        acc_next      = LEAF_W'(s_free_address >> BR_LOG2);
                        if (CMP_W'(s_free_address) >= (CMP_W'(top_reg) << LEAF_W)) begin
                            res_granted_next = 1'b0;
                            state_next       = ST_DONE;
                        end else begin
                            res_granted_next = 1'b1;
                            state_next       = ST_LEAF_RD;
                        end
                    end
                end
            end
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == LEAF_COUNT - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DESC_RD: begin
                state_next = ST_DESC_USE;
            end
            ST_DESC_USE: begin
                if (row_reg == '0 && tree_rdata_reg == ALL_ONES) begin
                    res_granted_next = 1'b0;
                    res_addr_next    = '0;
                    state_next       = ST_DONE;
                end else begin
                    acc_next = (row_reg == '0) ? LEAF_W'(fz)
                                               : ((acc_reg << BR_LOG2) | LEAF_W'(fz));
                    if (32'(row_reg) == TREE_ROWS - 1) begin
                        state_next = ST_LEAF_RD;
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = ST_DESC_RD;
                    end
                end
            end
            ST_LEAF_RD: begin
                state_next = ST_LEAF_USE;
            end
            ST_LEAF_USE: begin
                end_next    = leaf_end;
                row_next    = ROW_W'(TREE_ROWS - 1);
                node_next   = acc_reg >> BR_LOG2;
                branch_next = acc_reg[OFF_W-1:0];
                if (op_reg == OP_ALLOC) begin
                    res_granted_next = 1'b1;
                    res_addr_next    = ADDR_W'((32'(acc_reg) << BR_LOG2) | 32'(leaf_off));
                    cc_next          = leaf_end;
                    state_next = (32'(leaf_end) >= NUM_CLASSES) ? ST_DONE : ST_UPD_RD;
                end else begin
                    cc_next    = '0;
                    state_next = (leaf_end == '0) ? ST_DONE : ST_UPD_RD;
                end
            end
            ST_UPD_RD: begin
                state_next = ST_UPD_USE;
            end
            ST_UPD_USE: begin
                if (cont) begin
                    branch_next = node_reg[OFF_W-1:0];
                    node_next   = node_reg >> BR_LOG2;
                    row_next    = row_reg - 1'b1;
                    state_next  = ST_UPD_RD;
                end else begin
                    cc_next     = cc_reg + 1'b1;
                    row_next    = ROW_W'(TREE_ROWS - 1);
                    node_next   = acc_reg >> BR_LOG2;
                    branch_next = acc_reg[OFF_W-1:0];
                    if (op_reg == OP_ALLOC) begin
                        state_next = (32'(cc_reg) == NUM_CLASSES - 1) ? ST_DONE : ST_UPD_RD;
                    end else begin
                        state_next = (cc_reg + 1'b1 == end_reg) ? ST_DONE : ST_UPD_RD;
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = res_granted_reg;
                    m_addr_next    = res_addr_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            top_next   = cfg_sat;
            clr_next   = '0;
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            top_reg     <= CFG_W'(32);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            top_reg     <= top_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg         <= acc_next;
        node_reg        <= node_next;
        branch_reg      <= branch_next;
        row_reg         <= row_next;
        cc_reg          <= cc_next;
        end_reg         <= end_next;
        op_reg          <= op_next;
        cls_reg         <= cls_next;
        foff_reg        <= foff_next;
        res_granted_reg <= res_granted_next;
        res_addr_reg    <= res_addr_next;
        m_granted_reg   <= m_granted_next;
        m_addr_reg      <= m_addr_next;
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the power-of-two block allocator against its own bitmap-and-tree
// predictor. It drives allocate and free requests with random idling on both
// channels, rewrites the top branch count between phases, fills a small store
// to exhaustion and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hbba_pkg::*;

    localparam int NODES_PER_TREE = 33;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic              op;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] adr;
    } request_t;

    typedef struct {
        logic              op;
        logic [LEN_W-1:0]  len;
        logic              granted;
        logic [ADDR_W-1:0] adr;
    } grant_t;

    typedef struct {
        logic [ADDR_W-1:0] adr;
        logic [LEN_W-1:0]  len;
    } run_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic              s_op           = OP_ALLOC;
    logic [LEN_W-1:0]  s_run_length   = '0;
    logic [ADDR_W-1:0] s_free_address = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic              m_granted;
    logic [ADDR_W-1:0] m_block_address;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_wdata      = '0;

    hierarchical_bitmap_block_allocator_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_run_length    (s_run_length),
        .s_free_address  (s_free_address),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted       (m_granted),
        .m_block_address (m_block_address),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata)
    );

    // predictor state
    logic [31:0] leaf_map   [1024];
    logic [31:0] class_tree [NUM_CLASSES][NODES_PER_TREE];
    int          top_branches;

    request_t pending_reqs[$];
    grant_t   expected_grants[$];
    run_t     live_runs[$];
    request_t cur_req;

    int  fail_count   = 0;
    int  alloc_ok     = 0;
    int  alloc_full   = 0;
    int  free_count   = 0;
    int  phase_count  = 0;
    int  item_count   = 0;
    bit  calm         = 1'b0;
    int  s_gap        = 0;
    int  m_gap        = 0;
    int  quiet_cycles = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic logic [4:0] lowest_clear(logic [31:0] x);
        for (int i = 0; i < 32; i++) begin
            if (!x[i]) return 5'(i);
        end
        return 5'd0;
    endfunction

    function automatic int len_class(logic [LEN_W-1:0] n);
        return int'(n > 1) + int'(n > 2) + int'(n > 4) + int'(n > 8) + int'(n > 16);
    endfunction

    function automatic logic [31:0] class_mask(int c, logic [4:0] off);
        logic [31:0] w;
        w = (c >= 5) ? 32'hffff_ffff : ((32'd1 << (1 << c)) - 32'd1);
        return w << off;
    endfunction

    function automatic bit has_room(logic [31:0] leaf, int c);
        for (int k = 0; k < 32; k += (1 << c)) begin
            if ((leaf & class_mask(c, 5'(k))) == 32'd0) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [4:0] place_run(logic [31:0] leaf, int c);
        if (c == 5) return 5'd0;
        for (int k = 0; k < 32; k += (1 << c)) begin
            if ((leaf & class_mask(c, 5'(k))) == 32'd0) return 5'(k);
        end
        if (c == 4) return (leaf[15:0] != 16'd0) ? 5'd16 : 5'd0;
        return 5'd0;
    endfunction

    function automatic int room_classes(logic [31:0] leaf);
        int n;
        n = 0;
        for (int c = 0; c < NUM_CLASSES; c++) n += int'(has_room(leaf, c));
        return n;
    endfunction

    function automatic void reset_store();
        logic [31:0] absent;
        absent = (top_branches < 32) ? ~((32'd1 << top_branches) - 32'd1) : 32'd0;
        foreach (leaf_map[i]) leaf_map[i] = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            for (int n = 0; n < NODES_PER_TREE; n++) class_tree[c][n] = '0;
            class_tree[c][0] = absent;
        end
    endfunction

    function automatic void mark_full(int c, int leaf_i);
        int top;
        top = leaf_i >> 5;
        class_tree[c][1 + top][leaf_i & 31] = 1'b1;
        if (class_tree[c][1 + top] == 32'hffff_ffff) class_tree[c][0][top] = 1'b1;
    endfunction

    function automatic void mark_room(int c, int leaf_i);
        int top;
        bit had;
        top = leaf_i >> 5;
        had = (class_tree[c][1 + top] != 32'hffff_ffff);
        class_tree[c][1 + top][leaf_i & 31] = 1'b0;
        if (!had) class_tree[c][0][top] = 1'b0;
    endfunction

    function automatic grant_t serve_request(request_t r);
        grant_t     g;
        int         c;
        int         leaf_i;
        int         n;
        logic [4:0] off;
        c         = len_class(r.len);
        g.op      = r.op;
        g.len     = r.len;
        g.granted = 1'b1;
        if (r.op == OP_ALLOC) begin
            if (class_tree[c][0] == 32'hffff_ffff) begin
                g.granted = 1'b0;
                g.adr     = '0;
                return g;
            end
            leaf_i = lowest_clear(class_tree[c][0]);
            leaf_i = (leaf_i << 5) + lowest_clear(class_tree[c][1 + leaf_i]);
            off    = place_run(leaf_map[leaf_i], c);
            leaf_map[leaf_i] |= class_mask(c, off);
            n = room_classes(leaf_map[leaf_i]);
            for (int k = n; k < NUM_CLASSES; k++) mark_full(k, leaf_i);
            g.adr = ADDR_W'((leaf_i << 5) + off);
            return g;
        end
        g.adr = r.adr;
        if (int'(r.adr) >= (top_branches << 10)) begin
            g.granted = 1'b0;
            return g;
        end
        leaf_i = r.adr >> 5;
        leaf_map[leaf_i] &= ~class_mask(c, r.adr[4:0]);
        n = room_classes(leaf_map[leaf_i]);
        for (int k = 0; k < n; k++) mark_room(k, leaf_i);
        return g;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_grants.push_back(serve_request(cur_req));
            end
            if (!s_valid || s_ready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 11) == 0) begin
                    s_gap = $urandom_range(1, 15);
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    s_valid        <= 1'b1;
                    s_op           <= cur_req.op;
                    s_run_length   <= cur_req.len;
                    s_free_address <= cur_req.adr;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        grant_t g;
        run_t   r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_grants.size() == 0) begin
                    $error("result transfer with nothing expected: granted %0d address %0d",
                           m_granted, m_block_address);
                    fail_count++;
                end else begin
                    g = expected_grants.pop_front();
                    if (m_granted !== g.granted) begin
                        $error("granted: expected %0d, actual %0d", g.granted, m_granted);
                        fail_count++;
                    end
                    if (m_block_address !== g.adr) begin
                        $error("block_address: expected %0d, actual %0d",
                               g.adr, m_block_address);
                        fail_count++;
                    end
                    if (g.op == OP_ALLOC && g.granted) begin
                        r.adr = g.adr;
                        r.len = g.len;
                        live_runs.push_back(r);
                        alloc_ok++;
                    end else if (g.op == OP_ALLOC) begin
                        alloc_full++;
                    end else begin
                        free_count++;
                    end
                end
            end
            if (calm) begin
                m_ready <= 1'b1;
            end else if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                m_gap = $urandom_range(1, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_grants.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_req(logic op, logic [LEN_W-1:0] len, logic [ADDR_W-1:0] adr);
        request_t r;
        r.op  = op;
        r.len = len;
        r.adr = adr;
        while (pending_reqs.size() >= 4) @(posedge aclk);
        pending_reqs.push_back(r);
        item_count++;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_grants.size() > 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_top_branches(logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_wdata <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        top_branches = (v < 2) ? 2 : ((v > 32) ? 32 : int'(v));
        reset_store();
        live_runs.delete();
        cfg_valid <= 1'b0;
        phase_count++;
    endtask

    function automatic logic [LEN_W-1:0] random_len();
        case ($urandom_range(0, 9))
            0:       return LEN_W'($urandom_range(0, 63));
            1, 2:    return LEN_W'($urandom_range(9, 32));
            default: return LEN_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic release_live();
        run_t r;
        int   k;
        k = $urandom_range(0, live_runs.size() - 1);
        r = live_runs[k];
        live_runs.delete(k);
        push_req(OP_FREE, r.len, r.adr);
    endtask

    task automatic random_mix(int n);
        int roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55 || (roll < 85 && live_runs.size() == 0)) begin
                push_req(OP_ALLOC, random_len(), ADDR_W'($urandom));
            end else if (roll < 85) begin
                release_live();
            end else if (roll < 93) begin
                push_req(OP_FREE, LEN_W'($urandom_range(0, 63)),
                         ADDR_W'($urandom_range(0, (top_branches << 10) - 1)));
            end else begin
                push_req(OP_FREE, LEN_W'($urandom_range(0, 63)), ADDR_W'($urandom));
            end
        end
    endtask

    initial begin
        logic [LEN_W-1:0] lens [13];
        lens = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd8, 6'd9, 6'd16, 6'd17,
                 6'd32, 6'd33, 6'd63};
        top_branches = 32;
        reset_store();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        phase_count = 1;

        foreach (lens[i]) push_req(OP_ALLOC, lens[i], ADDR_W'($urandom));
        push_req(OP_FREE, 6'd1, 15'h7fff);
        push_req(OP_FREE, 6'd63, 15'h7fff);
        push_req(OP_FREE, 6'd8, 15'd0);
        push_req(OP_FREE, 6'd8, 15'd0);
        push_req(OP_FREE, 6'd16, 15'd27);
        push_req(OP_FREE, 6'd0, 15'd3);
        push_req(OP_FREE, 6'd2, 15'd65);
        push_req(OP_ALLOC, 6'd1, 15'h7fff);
        drain();
        random_mix(180);
        drain();

        write_top_branches(6'd0);
        for (int i = 0; i < 68; i++) push_req(OP_ALLOC, 6'd32, ADDR_W'($urandom));
        push_req(OP_ALLOC, 6'd1, '0);
        push_req(OP_FREE, 6'd4, 15'd2048);
        drain();
        while (live_runs.size() > 0) release_live();
        drain();
        random_mix(40);
        drain();

        write_top_branches(6'd63);
        random_mix(140);
        drain();
        write_top_branches(6'd1);
        random_mix(70);
        drain();
        write_top_branches(6'd33);
        random_mix(60);
        drain();
        write_top_branches(6'd7);
        calm = 1'b1;
        random_mix(100);
        drain();

        $display("%0d requests over %0d store settings: %0d runs placed, %0d refused",
                 item_count, phase_count, alloc_ok, alloc_full);
        $display("%0d frees answered, %0d mismatches", free_count, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/hbba_pkg.sv
hw/rtl/hbba_leaf_update.sv
hw/rtl/hierarchical_bitmap_block_allocator_unit.sv
tb/testbench.sv
